// ----- design/fcma_pkg.sv -----
// Package for the four-channel moving average unit.
// Shared widths, constants and the control struct; no dependencies.
package fcma_pkg;

  localparam int NCH      = 4;            // ranging channels per item
  localparam int DIST_W   = 16;           // distance width, mm
  localparam int OFS_W    = 11;           // calibration offset width, signed
  localparam int SAMPLE_W = NCH * DIST_W; // one tap of the delay line
  localparam int IDX_W    = 2;            // config register index width
  localparam int RES_W    = DIST_W + 2;   // signed width after offset subtract

  localparam logic [3:0] NODES_REQ = 4'd4; // only frames with this node count count

  // control from the top level to each channel lane
  typedef struct packed {
    logic upd;     // good item accepted: update running sum
    logic full;    // window already full before this item
    logic s1_adv;  // stage 1 loads
    logic s2_adv;  // stage 2 loads
    logic out_adv; // output register loads
    logic s2_avg;  // item in stage 2 takes the mean
  } ctl_t;

endpackage

// ----- design/fcma_cell.sv -----
// One tap of the sample delay line: holds four distances, passes them on.
// Depends on fcma_pkg.
module fcma_cell import fcma_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic [SAMPLE_W-1:0] d,
  output logic [SAMPLE_W-1:0] q
);

  logic [SAMPLE_W-1:0] q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ----- design/fcma_lane.sv -----
// Per-channel arithmetic: running sum, reciprocal-multiply mean, offset
// subtract and saturation. Depends on fcma_pkg.
module fcma_lane import fcma_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_t                    ctl,
  input  logic [DIST_W-1:0]       d_in,
  input  logic [DIST_W-1:0]       oldest,
  input  logic signed [OFS_W-1:0] ofs,
  output logic [DIST_W-1:0]       avg
);

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUM_W  = DIST_W + LOG_W;
  localparam int SHIFT  = SUM_W + LOG_W;
  localparam int MUL_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + MUL_W;
  // floor(2^SHIFT / WINDOW) + 1: exact quotient for any SUM_W-bit sum
  localparam longint unsigned MUL_FULL = (64'd1 << SHIFT) / WINDOW + 64'd1;
  localparam logic [MUL_W-1:0] MUL = MUL_W'(MUL_FULL);

  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DIST_W-1:0] d1_r, d2_r;
  logic [PROD_W-1:0] prod_r;
  logic [DIST_W-1:0] avg_r, avg_nxt;
  logic [DIST_W-1:0] v;
  logic signed [RES_W-1:0] diff;

  always_comb begin
    sum_nxt = sum_r - (ctl.full ? SUM_W'(oldest) : SUM_W'(0)) + SUM_W'(d_in);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.upd) begin
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.s1_adv) begin
      d1_r <= d_in;
    end
    if (ctl.s2_adv) begin
      d2_r   <= d1_r;
      prod_r <= PROD_W'(sum_r) * PROD_W'(MUL);
    end
    if (ctl.out_adv) begin
      avg_r <= avg_nxt;
    end
  end

  // select, subtract offset, clamp to 0..65535
  always_comb begin
    v    = ctl.s2_avg ? prod_r[SHIFT +: DIST_W] : d2_r;
    diff = $signed({2'b00, v}) - RES_W'(ofs);
    if (diff[RES_W-1]) begin
      avg_nxt = '0;
    end else if (diff[RES_W-2:DIST_W] != '0) begin
      avg_nxt = '1;
    end else begin
      avg_nxt = diff[DIST_W-1:0];
    end
  end

  assign avg = avg_r;

endmodule

// ----- design/four_channel_moving_average_unit.sv -----
// Four-channel moving average unit: top level.
// Depends on fcma_pkg, fcma_cell and fcma_lane.
//
// Filters ranging frames of four distances (mm). Frames whose node count is
// not 4 are accepted and dropped without a result. The first WINDOW-1 good
// frames pass their distances through (out_averaged = 0); from the WINDOW-th
// on, each channel gives the truncated mean of its last WINDOW samples
// (out_averaged = 1). The per-channel offset (cfg registers 0..3, signed
// 11 bit) is subtracted and the result is clamped to 0..65535.
// The last WINDOW samples sit in a row of WINDOW cells that shift by one on
// every good item; the cell at the far end supplies the sample leaving the
// running sum. Throughput is one item per cycle while out_stall is low, set
// by the running-sum update. There are three register stages: the sum update,
// then the reciprocal multiply, then the offset/saturate output register,
// which drives out_valid. Stalls propagate back through the three stages,
// and bubbles are squeezed out. Reset has no clearing pass: the cells need
// none since the fill count keeps unwritten taps out of the sum.
// Configuration writes are always ready and must only happen while idle.
module four_channel_moving_average_unit import fcma_pkg::*; #(
  parameter int WINDOW = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input items
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [3:0]              in_node_count,
  input  logic [DIST_W-1:0]       in_dist0,
  input  logic [DIST_W-1:0]       in_dist1,
  input  logic [DIST_W-1:0]       in_dist2,
  input  logic [DIST_W-1:0]       in_dist3,
  // result items
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [DIST_W-1:0]       out_avg0,
  output logic [DIST_W-1:0]       out_avg1,
  output logic [DIST_W-1:0]       out_avg2,
  output logic [DIST_W-1:0]       out_avg3,
  output logic                    out_averaged,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic signed [OFS_W-1:0] cfg_data
);

  localparam int FILL_W = $clog2(WINDOW + 1);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic s1_v_r, s2_v_r, out_valid_r;
  logic s1_avg_r, s2_avg_r, out_avg_r;
  logic signed [OFS_W-1:0] ofs_r [NCH];

  logic [SAMPLE_W-1:0] tap [WINDOW+1];
  logic [DIST_W-1:0]   dist_ch [NCH];
  logic [DIST_W-1:0]   lane_avg [NCH];

  logic good, full, item_avg;
  logic out_adv, s2_adv, s1_adv;
  ctl_t ctl;

  // pipeline advance: each stage moves when it is empty or the one after it frees up
  assign out_adv  = !out_valid_r || !out_stall;
  assign s2_adv   = !s2_v_r || out_adv;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_stall = !s1_adv;

  assign good     = in_valid && s1_adv && (in_node_count == NODES_REQ);
  assign full     = (fill_r == FILL_W'(WINDOW));
  assign item_avg = full || (fill_r == FILL_W'(WINDOW - 1));
  assign fill_nxt = (good && !full) ? fill_r + FILL_W'(1) : fill_r;

  always_comb begin
    ctl.upd     = good;
    ctl.full    = full;
    ctl.s1_adv  = s1_adv;
    ctl.s2_adv  = s2_adv;
    ctl.out_adv = out_adv;
    ctl.s2_avg  = s2_avg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      s1_avg_r    <= 1'b0;
      s2_avg_r    <= 1'b0;
      out_avg_r   <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      if (s1_adv) begin
        s1_v_r   <= good;
        s1_avg_r <= item_avg;
      end
      if (s2_adv) begin
        s2_v_r   <= s1_v_r;
        s2_avg_r <= s1_avg_r;
      end
      if (out_adv) begin
        out_valid_r <= s2_v_r;
        out_avg_r   <= s2_avg_r;
      end
    end
  end

  // offset registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NCH; i++) begin
        ofs_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      ofs_r[cfg_index] <= cfg_data;
    end
  end

  // sample delay line: tap[0] is the incoming item, tap[WINDOW] the oldest
  assign dist_ch[0] = in_dist0;
  assign dist_ch[1] = in_dist1;
  assign dist_ch[2] = in_dist2;
  assign dist_ch[3] = in_dist3;
  assign tap[0]     = {in_dist3, in_dist2, in_dist1, in_dist0};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    fcma_cell u_cell (
      .clk (clk),
      .en  (good),
      .d   (tap[i]),
      .q   (tap[i+1])
    );
  end

  for (genvar c = 0; c < NCH; c++) begin : g_lane
    fcma_lane #(.WINDOW(WINDOW)) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl    (ctl),
      .d_in   (dist_ch[c]),
      .oldest (tap[WINDOW][c*DIST_W +: DIST_W]),
      .ofs    (ofs_r[c]),
      .avg    (lane_avg[c])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_averaged = out_avg_r;
  assign out_avg0     = lane_avg[0];
  assign out_avg1     = lane_avg[1];
  assign out_avg2     = lane_avg[2];
  assign out_avg3     = lane_avg[3];

  // fill count saturates at the window length
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW))
    else $error("fill count past window");

  // a new result only comes out of a valid stage 2
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r))
    else $error("result without item in stage 2");

  // a mean is only given once the window has filled
  a_avg_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_avg_r) |-> full)
    else $error("mean given before window full");

  // input stalls only when the whole pipe is occupied and blocked
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_valid_r && out_stall))
    else $error("input stalled with room in pipe");

endmodule
